/* rtl/smia_pkg.sv */
`default_nettype none
package smia_pkg;

    localparam int OpW    = 4;
    localparam int DataW  = 64;
    localparam int IntW   = 32;
    localparam int DivStg = 32;   // one quotient bit per stage

    typedef enum logic [OpW-1:0] {
        OP_IADD  = 4'd0,
        OP_LADD  = 4'd1,
        OP_ISUB  = 4'd2,
        OP_IMUL  = 4'd3,
        OP_IDIV  = 4'd4,
        OP_IREM  = 4'd5,
        OP_INEG  = 4'd6,
        OP_LSHL  = 4'd7,
        OP_ISHL  = 4'd8,
        OP_ISHR  = 4'd9,
        OP_IUSHR = 4'd10,
        OP_IAND  = 4'd11,
        OP_LAND  = 4'd12,
        OP_IOR   = 4'd13,
        OP_LOR   = 4'd14,
        OP_IXOR  = 4'd15
    } op_t;

    localparam logic [5:0] LongShMask = 6'h3f;
    localparam logic [4:0] IntShMask  = 5'h1f;

    function automatic logic [DataW-1:0] sext32(input logic [IntW-1:0] v);
        sext32 = {{(DataW-IntW){v[IntW-1]}}, v};
    endfunction

    // item flowing down the divider pipe
    typedef struct packed {
        op_t              op;
        logic             is_div;
        logic             neg_q;
        logic             neg_r;
        logic [IntW-1:0]  dvd;     // shifts out dividend, shifts in quotient
        logic [IntW-1:0]  dvs;
        logic [IntW:0]    rem;
        logic [DataW-1:0] res;     // result, written in the last stage for divide ops
        logic             st;
    } stage_t;

endpackage
`default_nettype wire

/* rtl/stack_machine_integer_alu_core.sv */
// channel | dir | payload
// s_axis  | in  | tdata: action[3:0], operand_a[67:4], operand_b[131:68], zeros to 135
// m_axis  | out | tdata: result_value[63:0], status[64], zeros to 71
// every op passes through every stage, one item per cycle sustained while the output does not stall
// the 32 one-bit stages of the restoring divider set the depth; the multiply
// takes one stage and its product is registered before selection
// a stall freezes the whole pipe; s_axis_tready follows m_axis_tready or a free output
// reset clears the valid bits only
`default_nettype none
module stack_machine_integer_alu_core
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [135:0] s_axis_tdata,   // action, operand_a, operand_b
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [71:0]       m_axis_tdata    // result_value, status
);
    import smia_pkg::*;

    localparam int NStg = DivStg + 2;   // decode, mul/prep, divide steps

    logic            adv;
    logic [NStg:0]   vld_reg;
    stage_t          stg_reg [NStg+1];
    stage_t          stg_next[NStg+1];
    logic [IntW-1:0] prod_reg, prod_next;

    logic [OpW-1:0]   in_op;
    logic [DataW-1:0] in_a, in_b;
    assign in_op = s_axis_tdata[3:0];
    assign in_a  = s_axis_tdata[67:4];
    assign in_b  = s_axis_tdata[131:68];

    assign adv           = m_axis_tready || !vld_reg[NStg];
    assign s_axis_tready = adv;

    // stage 0: results of everything but multiply and divide, plus divide operand prep
    always_comb
    begin
        logic [IntW-1:0] a32, b32, an;
        logic [4:0]      sh5;
        logic [5:0]      sh6;
        a32 = in_a[IntW-1:0];
        b32 = in_b[IntW-1:0];
        sh5 = in_b[4:0] & IntShMask;
        sh6 = in_b[5:0] & LongShMask;
        an  = ~a32;
        stg_next[0]        = '0;
        stg_next[0].op     = op_t'(in_op);
        stg_next[0].is_div = (in_op == OP_IDIV) || (in_op == OP_IREM);
        stg_next[0].neg_q  = a32[IntW-1] ^ b32[IntW-1];
        stg_next[0].neg_r  = a32[IntW-1];
        stg_next[0].dvd    = a32[IntW-1] ? IntW'(0) - a32 : a32;
        stg_next[0].dvs    = b32[IntW-1] ? IntW'(0) - b32 : b32;
        stg_next[0].st     = stg_next[0].is_div && (b32 == '0);
        unique case (op_t'(in_op))
            OP_IADD:  stg_next[0].res = sext32(a32 + b32);
            OP_LADD:  stg_next[0].res = in_a + in_b;
            OP_ISUB:  stg_next[0].res = sext32(a32 - b32);
            OP_INEG:  stg_next[0].res = sext32(IntW'(0) - a32);
            OP_LSHL:  stg_next[0].res = in_a << sh6;
            OP_ISHL:  stg_next[0].res = sext32(a32 << sh5);
            OP_ISHR:  stg_next[0].res = a32[IntW-1] ? sext32(~(an >> sh5))
                                                    : DataW'(a32 >> sh5);
            OP_IUSHR: stg_next[0].res = sext32(a32 >> sh5);
            OP_IAND:  stg_next[0].res = sext32(a32 & b32);
            OP_LAND:  stg_next[0].res = in_a & in_b;
            OP_IOR:   stg_next[0].res = sext32(a32 | b32);
            OP_LOR:   stg_next[0].res = in_a | in_b;
            OP_IXOR:  stg_next[0].res = sext32(a32 ^ b32);
            default:  stg_next[0].res = '0;
        endcase
    end

    // stage 1: multiply in the prep stage (operands kept in stage 0 raw form)
    logic [IntW-1:0] ma_reg, mb_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ma_reg <= in_a[IntW-1:0];
            mb_reg <= in_b[IntW-1:0];
        end
    end
    assign prod_next = ma_reg * mb_reg;

    always_comb
    begin
        stg_next[1] = stg_reg[0];
        if (stg_reg[0].op == OP_IMUL)
            stg_next[1].res = '0;
    end

    // stages 2..NStg-1: one restoring divide step each; stage 2 also takes in the product
    genvar g;
    generate
        for (g = 2; g < NStg; g++)
        begin : g_div
            always_comb
            begin
                logic [IntW:0] tr;
                stg_next[g] = stg_reg[g-1];
                tr = {stg_reg[g-1].rem[IntW-1:0], stg_reg[g-1].dvd[IntW-1]};
                if (tr >= {1'b0, stg_reg[g-1].dvs})
                begin
                    stg_next[g].rem = tr - {1'b0, stg_reg[g-1].dvs};
                    stg_next[g].dvd = {stg_reg[g-1].dvd[IntW-2:0], 1'b1};
                end
                else
                begin
                    stg_next[g].rem = tr;
                    stg_next[g].dvd = {stg_reg[g-1].dvd[IntW-2:0], 1'b0};
                end
                if (g == 2 && stg_reg[1].op == OP_IMUL)
                    stg_next[g].res = sext32(prod_reg);
            end
        end
    endgenerate

    // last stage: sign fix-up of quotient and remainder, result select
    always_comb
    begin
        stage_t          p;
        logic [IntW-1:0] q, r;
        p = stg_reg[NStg-1];
        q = p.neg_q ? IntW'(0) - p.dvd : p.dvd;
        r = p.neg_r ? IntW'(0) - p.rem[IntW-1:0] : p.rem[IntW-1:0];
        stg_next[NStg] = p;
        if (p.st)
            stg_next[NStg].res = '0;
        else if (p.op == OP_IDIV)
            stg_next[NStg].res = sext32(q);
        else if (p.op == OP_IREM)
            stg_next[NStg].res = sext32(r);
    end

    assign m_axis_tdata  = {7'd0, stg_reg[NStg].st, stg_reg[NStg].res};
    assign m_axis_tvalid = vld_reg[NStg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NStg-1:0], s_axis_tvalid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= prod_next;
            for (int i = 0; i <= NStg; i++)
                stg_reg[i] <= stg_next[i];
        end
    end
endmodule
`default_nettype wire

/* rtl/smia_checker.sv */
`default_nettype none
module smia_checker
(
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [71:0]  m_axis_tdata
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output item dropped or changed under stall");
    a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output drains");
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[71:65] == '0)
        else $error("padding bits set");
    a_st: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[64] |-> m_axis_tdata[63:0] == '0)
        else $error("divide by zero result not zero");
endmodule

bind stack_machine_integer_alu_core smia_checker u_smia_checker (.*);
`default_nettype wire
